### rtl/core/lisf_pkg.sv
// lisf_pkg: shared types, constants and helpers of the lidar isolated spike filter.
// No dependencies.
`default_nettype none

package lisf_pkg;

  localparam int unsigned RangeBits = 16;
  localparam int unsigned IntenBits = 16;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned DataBits  = ((RangeBits + IntenBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KindFinite = 2'd0,
    KindPosInf = 2'd1,
    KindNegInf = 2'd2,
    KindNan    = 2'd3
  } kind_e;

  localparam logic [1:0] CfgThreshold = 2'd0;
  localparam logic [1:0] CfgRangeMin  = 2'd1;
  localparam logic [1:0] CfgRangeMax  = 2'd2;

  typedef struct packed {
    logic                 last;
    logic [IntenBits-1:0] intensity;
    kind_e                kind;
    logic [RangeBits-1:0] range;
  } sample_t;

  typedef struct packed {
    logic [CfgBits-1:0] threshold;
    logic [CfgBits-1:0] win_lo;
    logic [CfgBits-1:0] win_hi;
  } cfg_t;

  typedef struct packed {
    logic [1:0] count;
    logic [1:0] free;
  } q_stat_t;

  // finite value c farther than thr from neighbour (nr, nk)
  function automatic logic far_from(input logic [RangeBits-1:0] c,
                                    input logic [RangeBits-1:0] nr,
                                    input kind_e                nk,
                                    input logic [CfgBits-1:0]   thr);
    logic [RangeBits-1:0] gap;
    logic                 res;
    gap = (c >= nr) ? (c - nr) : (nr - c);
    unique case (nk)
      KindPosInf, KindNegInf: res = 1'b1;
      KindNan:                res = 1'b0;
      default:                res = gap > RangeBits'(thr);
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lisf_window.sv
// lisf_window: three-sample window state and spike decision for one beat.
// Uses lisf_pkg.
`default_nettype none

module lisf_window (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire lisf_pkg::sample_t in_i,
  input  wire lisf_pkg::cfg_t    cfg_i,
  output logic [1:0]            nres_o,
  output lisf_pkg::sample_t     res0_o,
  output lisf_pkg::sample_t     res1_o
);

  logic [1:0]        pos_q, pos_d;
  lisf_pkg::sample_t held_q, held_d;
  logic [lisf_pkg::RangeBits-1:0] prev_range_q, prev_range_d;
  lisf_pkg::kind_e   prev_kind_q, prev_kind_d;

  lisf_pkg::sample_t cur, filt;
  logic              in_window;

  always_comb begin
    cur = in_i;
    if (in_i.kind != lisf_pkg::KindFinite) begin
      cur.range = '0;
    end

    in_window = (held_q.kind == lisf_pkg::KindFinite) &&
                (held_q.range >= lisf_pkg::RangeBits'(cfg_i.win_lo)) &&
                (held_q.range <= lisf_pkg::RangeBits'(cfg_i.win_hi));

    filt      = held_q;
    filt.last = 1'b0;
    if (pos_q[1] && in_window &&
        lisf_pkg::far_from(held_q.range, prev_range_q, prev_kind_q, cfg_i.threshold) &&
        lisf_pkg::far_from(held_q.range, cur.range, cur.kind, cfg_i.threshold)) begin
      filt.range     = '0;
      filt.kind      = lisf_pkg::KindPosInf;
      filt.intensity = '0;
    end

    res1_o = cur;
    if (pos_q == 2'd0) begin
      res0_o = cur;
      nres_o = cur.last ? 2'd1 : 2'd0;
    end else begin
      res0_o = filt;
      nres_o = cur.last ? 2'd2 : 2'd1;
    end

    pos_d        = pos_q;
    held_d       = held_q;
    prev_range_d = prev_range_q;
    prev_kind_d  = prev_kind_q;
    if (adv_i) begin
      if (pos_q == 2'd0) begin
        if (!cur.last) begin
          held_d = cur;
          pos_d  = 2'd1;
        end
      end else begin
        prev_range_d = filt.range;
        prev_kind_d  = filt.kind;
        held_d       = cur;
        pos_d        = cur.last ? 2'd0 : 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q       <= held_d;
    prev_range_q <= prev_range_d;
    prev_kind_q  <= prev_kind_d;
  end

endmodule

`default_nettype wire

### rtl/core/lisf_outq.sv
// lisf_outq: two-entry result queue; takes up to two results per cycle, emits one beat.
// Uses lisf_pkg.
`default_nettype none

module lisf_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        push_i,
  input  wire lisf_pkg::sample_t d0_i,
  input  wire lisf_pkg::sample_t d1_i,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output lisf_pkg::sample_t      data_o,
  output lisf_pkg::q_stat_t      stat_o
);

  lisf_pkg::sample_t ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q ^ push_i[0];
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + push_i - {1'b0, pop_i};
    valid_o     = cnt_q != 2'd0;
    data_o      = ent_q[rd_q];
    stat_o.count = cnt_q;
    stat_o.free  = 2'd2 - cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i != 2'd0) begin
      ent_q[wr_q] <= d0_i;
    end
    if (push_i == 2'd2) begin
      ent_q[~wr_q] <= d1_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lidar_isolated_spike_filter.sv
// lidar_isolated_spike_filter: top level; input register, window logic, result queue.
// Uses lisf_pkg, lisf_window, lisf_outq.
// Throughput: one beat per cycle while the result queue has room for the beat's results.
// A last-of-scan beat behind a held sample pushes two results only into an empty queue.
// Results: a beat is held in the input register, then pushed into the result queue on advance.
// Reset: async active low; clears handshake, queue, window position; cfg to 100 / 0 / 65535.
`default_nettype none

module lidar_isolated_spike_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [lisf_pkg::DataBits-1:0] s_axis_tdata,  // range_mm, intensity
  input  wire logic [1:0]                    s_axis_tuser,  // range_kind
  input  wire logic                          s_axis_tlast,  // scan_last
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [lisf_pkg::DataBits-1:0]      m_axis_tdata,  // out_range_mm, out_intensity
  output logic [1:0]                         m_axis_tuser,  // out_kind
  output logic                               m_axis_tlast,  // out_last
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [lisf_pkg::CfgBits-1:0]  cfg_data_i
);

  localparam int unsigned RB = lisf_pkg::RangeBits;
  localparam int unsigned IB = lisf_pkg::IntenBits;

  lisf_pkg::cfg_t    cfg_q;
  logic              in_valid_q;
  lisf_pkg::sample_t in_q, in_beat;
  logic              adv;
  logic [1:0]        nres;
  lisf_pkg::sample_t res0, res1, q_data;
  lisf_pkg::q_stat_t q_stat;
  logic              pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= lisf_pkg::CfgBits'(100);
      cfg_q.win_lo    <= '0;
      cfg_q.win_hi    <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lisf_pkg::CfgThreshold: cfg_q.threshold <= cfg_data_i;
        lisf_pkg::CfgRangeMin:  cfg_q.win_lo    <= cfg_data_i;
        lisf_pkg::CfgRangeMax:  cfg_q.win_hi    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_beat.range     = s_axis_tdata[RB-1:0];
    in_beat.intensity = s_axis_tdata[RB+IB-1:RB];
    in_beat.kind      = lisf_pkg::kind_e'(s_axis_tuser);
    in_beat.last      = s_axis_tlast;
  end

  assign adv           = in_valid_q && (nres <= q_stat.free);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_beat;
    end
  end

  lisf_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .in_i   (in_q),
    .cfg_i  (cfg_q),
    .nres_o (nres),
    .res0_o (res0),
    .res1_o (res1)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  lisf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv ? nres : 2'd0),
    .d0_i    (res0),
    .d1_i    (res1),
    .pop_i   (pop),
    .valid_o (m_axis_tvalid),
    .data_o  (q_data),
    .stat_o  (q_stat)
  );

  assign m_axis_tdata = lisf_pkg::DataBits'({q_data.intensity, q_data.range});
  assign m_axis_tuser = q_data.kind;
  assign m_axis_tlast = q_data.last;

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= 2'd2)
    else $error("result queue overfilled");

  a_q_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (q_stat.count == $past(q_stat.count) + ($past(adv) ? $past(nres) : 2'd0)
              - {1'b0, $past(pop)}))
    else $error("result queue count lost track of pushes and pops");

  a_adv_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> $stable(in_q))
    else $error("stalled window beat changed");

endmodule

`default_nettype wire

### sim/tb_lidar_isolated_spike_filter.sv
// Testbench for lidar_isolated_spike_filter: directed scans, then random scans under several
// threshold / range settings, with random gaps on both streams and one long output stall.
// Depends on lisf_pkg and the lidar_isolated_spike_filter RTL.
`timescale 1ns / 100ps

module tb_lidar_isolated_spike_filter;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [lisf_pkg::DataBits-1:0] s_axis_tdata;   // range_mm, intensity
  logic [1:0]                    s_axis_tuser;   // range_kind
  logic                          s_axis_tlast;   // scan_last
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [lisf_pkg::DataBits-1:0] m_axis_tdata;   // out_range_mm, out_intensity
  logic [1:0]                    m_axis_tuser;   // out_kind
  logic                          m_axis_tlast;   // out_last
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [1:0]                    cfg_index_i;
  logic [lisf_pkg::CfgBits-1:0]  cfg_data_i;

  lidar_isolated_spike_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state
  logic [15:0]       win_thr;
  logic [15:0]       win_min;
  logic [15:0]       win_max;
  lisf_pkg::sample_t prev_smp;
  lisf_pkg::sample_t held_smp;
  int unsigned       held_pos;

  lisf_pkg::sample_t scan_q[$];
  lisf_pkg::sample_t filtered_q[$];
  lisf_pkg::sample_t in_cur;
  lisf_pkg::sample_t exp_b;
  logic              in_busy;
  logic              in_fire;
  logic              out_fire;
  logic              hold_start;
  int unsigned       in_wait;
  int unsigned       out_wait;
  int unsigned       hold_left;
  int unsigned       in_gap_max;
  int unsigned       out_gap_max;
  int unsigned       err_count;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic beyond(input logic [15:0] c, input lisf_pkg::sample_t nb);
    logic [15:0] d;
    d = (c >= nb.range) ? (c - nb.range) : (nb.range - c);
    if (nb.kind == lisf_pkg::KindPosInf || nb.kind == lisf_pkg::KindNegInf) return 1'b1;
    if (nb.kind == lisf_pkg::KindNan) return 1'b0;
    return d > win_thr;
  endfunction

  task automatic filter_predict(input lisf_pkg::sample_t s);
    lisf_pkg::sample_t inb;
    lisf_pkg::sample_t outb;
    inb = s;
    if (inb.kind != lisf_pkg::KindFinite) inb.range = '0;
    if (held_pos == 0) begin
      if (inb.last) begin
        filtered_q.push_back(inb);
      end else begin
        held_smp = inb;
        held_pos = 1;
      end
    end else begin
      outb = held_smp;
      outb.last = 1'b0;
      if (held_pos >= 2 && outb.kind == lisf_pkg::KindFinite && outb.range >= win_min &&
          outb.range <= win_max && beyond(outb.range, prev_smp) &&
          beyond(outb.range, inb)) begin
        outb.range = '0;
        outb.kind = lisf_pkg::KindPosInf;
        outb.intensity = '0;
      end
      filtered_q.push_back(outb);
      prev_smp = outb;
      if (inb.last) begin
        filtered_q.push_back(inb);
        held_smp = '0;
        held_pos = 0;
      end else begin
        held_smp = inb;
        held_pos = 2;
      end
    end
  endtask

  task automatic compare_field(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
      err_count++;
    end
  endtask

  // input acceptance, prediction and result checking
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      filter_predict(in_cur);
      in_fire = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_fire = 1'b1;
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got range %0d kind %0d inten %0d %0d",
                 $time, m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[31:16], m_axis_tlast);
        err_count++;
      end else begin
        exp_b = filtered_q.pop_front();
        compare_field("range", exp_b.range, m_axis_tdata[15:0]);
        compare_field("kind", exp_b.kind, m_axis_tuser);
        compare_field("intensity", exp_b.intensity, m_axis_tdata[31:16]);
        compare_field("last", exp_b.last, m_axis_tlast);
      end
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    if (in_fire) begin
      in_fire = 1'b0;
      in_busy = 1'b0;
      in_wait = $urandom_range(0, in_gap_max);
    end
    if (!in_busy && scan_q.size() > 0) begin
      if (in_wait > 0) begin
        in_wait--;
      end else begin
        in_cur = scan_q.pop_front();
        in_busy = 1'b1;
        s_axis_tdata <= {in_cur.intensity, in_cur.range};
        s_axis_tuser <= in_cur.kind;
        s_axis_tlast <= in_cur.last;
      end
    end
    s_axis_tvalid <= in_busy;
  end

  // result receiver
  always @(negedge clk_i) begin
    if (out_fire) begin
      out_fire = 1'b0;
      out_wait = $urandom_range(0, out_gap_max);
    end
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic add_sample(input logic [15:0] r, input lisf_pkg::kind_e k,
                            input logic [15:0] inten, input logic lst);
    lisf_pkg::sample_t s;
    s.range = r;
    s.kind = k;
    s.intensity = inten;
    s.last = lst;
    scan_q.push_back(s);
  endtask

  task automatic queue_scan(input int unsigned len, input int unsigned spread);
    logic [15:0]       base;
    int unsigned       roll;
    int                off;
    lisf_pkg::sample_t s;
    base = 16'($urandom_range(0, 65535));
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      s.intensity = 16'($urandom_range(0, 65535));
      s.last = (i == len - 1);
      s.kind = lisf_pkg::KindFinite;
      if (roll < 60) begin
        off = int'($urandom_range(0, 2 * spread)) - int'(spread);
        s.range = 16'(int'(base) + off);
      end else if (roll < 80) begin
        off = int'($urandom_range(spread + 1, 4 * spread + 4));
        if ($urandom_range(0, 1)) off = -off;
        s.range = 16'(int'(base) + off);
      end else if (roll < 88) begin
        s.range = 16'($urandom_range(0, 65535));
      end else if (roll < 95) begin
        s.range = 16'($urandom_range(0, 65535));
        s.kind = lisf_pkg::kind_e'($urandom_range(1, 3));
      end else begin
        // stray beat: any kind, random end-of-scan flag
        s.range = 16'($urandom_range(0, 65535));
        s.kind = lisf_pkg::kind_e'($urandom_range(0, 3));
        s.last = 1'($urandom_range(0, 1)) | (i == len - 1);
      end
      scan_q.push_back(s);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      lisf_pkg::CfgThreshold: win_thr = val;
      lisf_pkg::CfgRangeMin:  win_min = val;
      lisf_pkg::CfgRangeMax:  win_max = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (scan_q.size() != 0 || in_busy || filtered_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  initial begin
    int unsigned thr_tab[6]  = '{100, 0, 65535, 250, 300, 40};
    int unsigned min_tab[6]  = '{0, 0, 0, 2000, 40000, 0};
    int unsigned max_tab[6]  = '{65535, 65535, 65535, 60000, 1000, 65535};
    int unsigned igap_tab[6] = '{0, 3, 15, 0, 7, 15};
    int unsigned ogap_tab[6] = '{0, 15, 3, 0, 7, 15};
    int unsigned roll;
    int unsigned len;
    int unsigned added;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    win_thr = 16'd100;
    win_min = 16'd0;
    win_max = 16'hFFFF;
    prev_smp = '0;
    held_smp = '0;
    held_pos = 0;
    in_busy = 1'b0;
    in_fire = 1'b0;
    out_fire = 1'b0;
    hold_start = 1'b0;
    in_wait = 0;
    out_wait = 0;
    hold_left = 0;
    in_gap_max = 0;
    out_gap_max = 2;
    err_count = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed scans on reset settings
    add_sample(16'd1000, lisf_pkg::KindFinite, 16'd11, 1'b0);
    add_sample(16'd5000, lisf_pkg::KindFinite, 16'd22, 1'b0);   // lone spike
    add_sample(16'd1000, lisf_pkg::KindFinite, 16'd33, 1'b0);
    add_sample(16'd1010, lisf_pkg::KindFinite, 16'd44, 1'b1);
    add_sample(16'hFFFF, lisf_pkg::KindNan, 16'hFFFF, 1'b1);    // one-sample scan
    add_sample(16'd0, lisf_pkg::KindFinite, 16'd0, 1'b0);       // two-sample scan
    add_sample(16'hFFFF, lisf_pkg::KindFinite, 16'hFFFF, 1'b1);
    add_sample(16'd100, lisf_pkg::KindFinite, 16'd1, 1'b0);     // chain through filtered neighbor
    add_sample(16'd3000, lisf_pkg::KindFinite, 16'd2, 1'b0);
    add_sample(16'd6000, lisf_pkg::KindFinite, 16'd3, 1'b0);
    add_sample(16'd100, lisf_pkg::KindFinite, 16'd4, 1'b1);
    add_sample(16'd500, lisf_pkg::KindFinite, 16'd5, 1'b0);     // infinite neighbors
    add_sample(16'd900, lisf_pkg::KindFinite, 16'd6, 1'b0);
    add_sample(16'd1234, lisf_pkg::KindPosInf, 16'd7, 1'b0);
    add_sample(16'hABCD, lisf_pkg::KindNegInf, 16'd8, 1'b1);
    add_sample(16'd500, lisf_pkg::KindFinite, 16'd9, 1'b0);     // NaN neighbor
    add_sample(16'd2000, lisf_pkg::KindFinite, 16'd10, 1'b0);
    add_sample(16'h5A5A, lisf_pkg::KindNan, 16'd11, 1'b0);
    add_sample(16'd500, lisf_pkg::KindFinite, 16'd12, 1'b1);
    add_sample(16'd0, lisf_pkg::KindFinite, 16'hFFFF, 1'b0);    // extremes
    add_sample(16'hFFFF, lisf_pkg::KindFinite, 16'h8000, 1'b0);
    add_sample(16'd0, lisf_pkg::KindFinite, 16'h0001, 1'b1);
    add_sample(16'd200, lisf_pkg::KindFinite, 16'd13, 1'b0);    // distance equal to threshold
    add_sample(16'd300, lisf_pkg::KindFinite, 16'd14, 1'b0);
    add_sample(16'd200, lisf_pkg::KindFinite, 16'd15, 1'b1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      cfg_write(lisf_pkg::CfgThreshold, 16'(thr_tab[p]));
      cfg_write(lisf_pkg::CfgRangeMin, 16'(min_tab[p]));
      cfg_write(lisf_pkg::CfgRangeMax, 16'(max_tab[p]));
      in_gap_max = igap_tab[p];
      out_gap_max = ogap_tab[p];
      added = 0;
      while (added < 225) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) len = 1;
        else if (roll < 20) len = 2;
        else if (roll < 92) len = $urandom_range(3, 12);
        else len = $urandom_range(20, 60);
        queue_scan(len, (thr_tab[p] > 8000) ? 8000 : thr_tab[p]);
        added += len;
      end
      if (p == 3) begin
        // long output stall while input keeps coming
        @(posedge clk_i);
        hold_start = 1'b1;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### lidar_isolated_spike_filter.f
rtl/core/lisf_pkg.sv
rtl/core/lisf_window.sv
rtl/core/lisf_outq.sv
rtl/core/lidar_isolated_spike_filter.sv
sim/tb_lidar_isolated_spike_filter.sv
